### rtl/core/lcsr_pkg.sv
package lcsr_pkg;

  // Fixed field widths of the channels
  localparam int CMD_W   = 2;
  localparam int MASS_W  = 24;
  localparam int RAW_W   = 24;
  localparam int VALUE_W = 32;
  localparam int CONV_W  = 16;
  localparam int SCALE_W = 48;

  // Saturation limits
  localparam logic [VALUE_W-1:0] VALUE_MAX = 32'h7FFF_FFFF;
  localparam logic [VALUE_W-1:0] VALUE_MIN = 32'h8000_0000;
  localparam logic [SCALE_W-1:0] SCALE_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [SCALE_W-1:0] SCALE_MIN = 48'h8000_0000_0000;

  typedef enum logic [1:0] {
    OP_NONE    = 2'd0,
    OP_MEASURE = 2'd1,
    OP_TARE    = 2'd2,
    OP_CAL     = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_HIGH  = 3'd1,
    PH_LOW   = 3'd2,
    PH_XHIGH = 3'd3,
    PH_XLOW  = 3'd4
  } phase_t;

  typedef enum logic {
    CS_READY = 1'b0,
    CS_CALC  = 1'b1
  } ctl_state_t;

  typedef enum logic {
    AOP_MUL = 1'b0,
    AOP_DIV = 1'b1
  } arith_op_t;

  typedef struct packed {
    logic      start;
    arith_op_t op;
  } arith_req_t;

  typedef struct packed {
    logic sck;
    logic last;
    op_t  op;
  } ser_stat_t;

endpackage

### rtl/core/lcsr_in_if.sv
interface lcsr_in_if;
  import lcsr_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic              dout;
  logic [MASS_W-1:0] mass_q8;

  modport source (output valid, output command, output dout, output mass_q8, input ready);
  modport sink (input valid, input command, input dout, input mass_q8, output ready);
endinterface

### rtl/core/lcsr_out_if.sv
interface lcsr_out_if;
  import lcsr_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      sck;
  logic                      done_res;
  logic                      status;
  logic signed [RAW_W-1:0]   raw;
  logic signed [VALUE_W-1:0] value;
  logic [CONV_W-1:0]         conversions;

  modport source (
    output valid, output sck, output done_res, output status,
    output raw, output value, output conversions, input ready
  );
  modport sink (
    input valid, input sck, input done_res, input status,
    input raw, input value, input conversions, output ready
  );
endinterface

### rtl/core/lcsr_serial.sv
module lcsr_serial #(
  parameter int DATA_BITS = 24
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        fire,
  input  logic [lcsr_pkg::CMD_W-1:0]  command,
  input  logic                        dout,
  input  logic [lcsr_pkg::MASS_W-1:0] mass_q8,
  output lcsr_pkg::ser_stat_t         stat,
  output logic [DATA_BITS-1:0]        word,
  output logic [lcsr_pkg::MASS_W-1:0] mass
);
  import lcsr_pkg::*;

  localparam int CNT_W = $clog2(DATA_BITS + 1);

  phase_t              phase_r, phase_nxt;
  logic [CNT_W-1:0]    bit_cnt_r, bit_cnt_nxt;
  logic [DATA_BITS-1:0] shift_r, shift_nxt;
  op_t                 op_r, op_nxt;
  logic [MASS_W-1:0]   mass_r, mass_nxt;
  logic                start_ok;

  // Converter ready and a real command
  assign start_ok = (op_t'(command) != OP_NONE) && !dout;

  // Advance the tick sequencer
  always_comb begin
    phase_nxt   = phase_r;
    bit_cnt_nxt = bit_cnt_r;
    shift_nxt   = shift_r;
    op_nxt      = op_r;
    mass_nxt    = mass_r;
    if (fire) begin
      case (phase_r)
        PH_IDLE: begin
          if (start_ok) begin
            op_nxt      = op_t'(command);
            if (op_t'(command) == OP_CAL) begin
              mass_nxt = mass_q8;
            end
            bit_cnt_nxt = '0;
            shift_nxt   = '0;
            phase_nxt   = PH_HIGH;
          end
        end
        PH_HIGH: begin
          shift_nxt   = {shift_r[DATA_BITS-2:0], dout};
          bit_cnt_nxt = bit_cnt_r + 1'b1;
          phase_nxt   = PH_LOW;
        end
        PH_LOW: begin
          phase_nxt = (bit_cnt_r == CNT_W'(DATA_BITS)) ? PH_XHIGH : PH_HIGH;
        end
        PH_XHIGH: begin
          phase_nxt = PH_XLOW;
        end
        PH_XLOW: begin
          phase_nxt   = PH_IDLE;
          op_nxt      = OP_NONE;
          bit_cnt_nxt = '0;
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  // Drive tick status from the current phase
  always_comb begin
    stat.sck  = phase_r inside {PH_HIGH, PH_XHIGH};
    stat.last = (phase_r == PH_XLOW);
    stat.op   = op_r;
  end

  assign word = shift_r;
  assign mass = mass_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      bit_cnt_r <= '0;
      shift_r   <= '0;
      op_r      <= OP_NONE;
      mass_r    <= '0;
    end else begin
      phase_r   <= phase_nxt;
      bit_cnt_r <= bit_cnt_nxt;
      shift_r   <= shift_nxt;
      op_r      <= op_nxt;
      mass_r    <= mass_nxt;
    end
  end

  a_cnt_full_at_tail: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_XHIGH) || (phase_r == PH_XLOW) |-> bit_cnt_r == CNT_W'(DATA_BITS))
    else $error("bit count not complete in trailing pulse");

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> (bit_cnt_r == '0) && (op_r == OP_NONE))
    else $error("idle sequencer holds stale count or command");

endmodule

### rtl/core/lcsr_arith_unit.sv
module lcsr_arith_unit #(
  parameter int MAG_W = 24,
  parameter int QUO_W = 48
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  lcsr_pkg::arith_req_t                req,
  input  logic [MAG_W-1:0]                    mag,
  input  logic [lcsr_pkg::SCALE_W-1:0]        mcand,
  input  logic [QUO_W-1:0]                    dividend,
  output logic                                busy,
  output logic [lcsr_pkg::SCALE_W+MAG_W-1:0]  product,
  output logic [QUO_W-1:0]                    quotient
);
  import lcsr_pkg::*;

  localparam int AW        = SCALE_W + 1;
  localparam int STEPS_MAX = (QUO_W > MAG_W) ? QUO_W : MAG_W;
  localparam int STEP_W    = $clog2(STEPS_MAX);

  logic                busy_r, busy_nxt;
  arith_op_t           op_r, op_nxt;
  logic [STEP_W-1:0]   cnt_r, cnt_nxt;
  logic [SCALE_W-1:0]  acc_r, acc_nxt;
  logic [MAG_W-1:0]    mlo_r, mlo_nxt;
  logic [QUO_W-1:0]    quo_r, quo_nxt;
  logic [SCALE_W-1:0]  opnd_r, opnd_nxt;

  logic [AW-1:0]       add_x, add_y;
  logic                add_sub;
  logic [AW:0]         add_s;
  logic [MAG_W:0]      trial;
  logic                ge;

  // Shared adder: accumulate for multiply, trial subtract for divide
  assign trial = {acc_r[MAG_W-1:0], quo_r[QUO_W-1]};

  always_comb begin
    if (op_r == AOP_DIV) begin
      add_x   = AW'(trial);
      add_y   = AW'(opnd_r[MAG_W-1:0]);
      add_sub = 1'b1;
    end else begin
      add_x   = {1'b0, acc_r};
      add_y   = mlo_r[0] ? {1'b0, opnd_r} : '0;
      add_sub = 1'b0;
    end
    add_s = {1'b0, add_x} + {1'b0, add_y ^ {AW{add_sub}}} + (AW + 1)'(add_sub);
  end

  assign ge = add_s[AW];

  // Load operands, then one bit per cycle
  always_comb begin
    busy_nxt = busy_r;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    mlo_nxt  = mlo_r;
    quo_nxt  = quo_r;
    opnd_nxt = opnd_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      op_nxt   = req.op;
      acc_nxt  = '0;
      mlo_nxt  = mag;
      quo_nxt  = dividend;
      opnd_nxt = (req.op == AOP_DIV) ? SCALE_W'(mag) : mcand;
      cnt_nxt  = (req.op == AOP_DIV) ? STEP_W'(QUO_W - 1) : STEP_W'(MAG_W - 1);
    end else if (busy_r) begin
      if (op_r == AOP_DIV) begin
        acc_nxt = ge ? SCALE_W'(add_s[MAG_W-1:0]) : SCALE_W'(trial[MAG_W-1:0]);
        quo_nxt = {quo_r[QUO_W-2:0], ge};
      end else begin
        acc_nxt = add_s[SCALE_W:1];
        mlo_nxt = {add_s[0], mlo_r[MAG_W-1:1]};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end
    end
  end

  assign busy     = busy_r;
  assign product  = {acc_r, mlo_r};
  assign quotient = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      op_r   <= AOP_MUL;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      op_r   <= op_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    mlo_r  <= mlo_nxt;
    quo_r  <= quo_nxt;
    opnd_r <= opnd_nxt;
  end

  a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r)
    else $error("arithmetic unit started while busy");

  a_run_to_end: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && (cnt_r != '0) |=> busy_r)
    else $error("arithmetic unit stopped before last step");

endmodule

### rtl/core/load_cell_serial_reader_calibrator.sv
// Every accepted transaction is one serial half-period tick; its result is registered and
// offered in the cycle after acceptance, and plain ticks are taken one per cycle while the
// output is not stalled. The finishing tick of a measure runs one shift-add step per bit
// of |raw - tare|, and that of a calibrate with a nonzero offset one quotient bit per step,
// both in the shared add/subtract unit; input is not ready meanwhile.
// Synchronous active-low reset: idle, tare 0, scale one (2^SCALE_FRACTION_BITS), count 0.
module load_cell_serial_reader_calibrator #(
  parameter int DATA_BITS           = 24,
  parameter int SCALE_FRACTION_BITS = 24
) (
  input  logic       clk,
  input  logic       rst_n,
  lcsr_in_if.sink    in_chan,
  lcsr_out_if.source out_chan
);
  import lcsr_pkg::*;

  localparam int DIFF_W  = DATA_BITS + 1;
  localparam int QUO_W   = MASS_W + SCALE_FRACTION_BITS;
  localparam int PROD_W  = SCALE_W + DATA_BITS;
  localparam int QX_W    = (QUO_W > SCALE_W) ? QUO_W : SCALE_W;
  localparam int SAT_LSB = SCALE_FRACTION_BITS + VALUE_W - 1;
  localparam logic [SCALE_W-1:0] SCALE_ONE = SCALE_W'(1) << SCALE_FRACTION_BITS;

  ctl_state_t ctl_r, ctl_nxt;
  logic       in_fire, out_slot, load_now, load_calc, defer;

  ser_stat_t            ser;
  logic [DATA_BITS-1:0] word;
  logic [MASS_W-1:0]    mass;

  logic signed [DIFF_W-1:0]    raw_ext, tare_ext, diff;
  logic [DATA_BITS-1:0]        diff_mag;
  logic [SCALE_W-1:0]          scale_mag;
  logic [RAW_W-1:0]            raw_out;

  logic signed [DATA_BITS-1:0] tare_r, tare_nxt;
  logic signed [SCALE_W-1:0]   scale_r, scale_nxt;
  logic [CONV_W-1:0]           conv_r, conv_nxt;
  logic                        neg_r, neg_nxt;
  arith_op_t                   dop_r, dop_nxt;
  logic [RAW_W-1:0]            raw_hold_r, raw_hold_nxt;

  arith_req_t         req;
  logic               arith_busy;
  logic [PROD_W-1:0]  product;
  logic [QUO_W-1:0]   quotient;

  logic                  mul_over, mul_rem;
  logic [VALUE_W-2:0]    mul_q;
  logic [VALUE_W-1:0]    meas_val;
  logic [QX_W-1:0]       q_x;
  logic                  cal_over;
  logic [SCALE_W-1:0]    cal_scale;

  logic               out_valid_r, out_valid_nxt;
  logic               out_sck_r, out_sck_nxt;
  logic               out_done_r, out_done_nxt;
  logic               out_status_r, out_status_nxt;
  logic [RAW_W-1:0]   out_raw_r, out_raw_nxt;
  logic [VALUE_W-1:0] out_value_r, out_value_nxt;
  logic [CONV_W-1:0]  out_conv_r, out_conv_nxt;

  lcsr_serial #(
    .DATA_BITS (DATA_BITS)
  ) u_serial (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (in_fire),
    .command (in_chan.command),
    .dout    (in_chan.dout),
    .mass_q8 (in_chan.mass_q8),
    .stat    (ser),
    .word    (word),
    .mass    (mass)
  );

  lcsr_arith_unit #(
    .MAG_W (DATA_BITS),
    .QUO_W (QUO_W)
  ) u_arith (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (req),
    .mag      (diff_mag),
    .mcand    (scale_mag),
    .dividend ({mass, {SCALE_FRACTION_BITS{1'b0}}}),
    .busy     (arith_busy),
    .product  (product),
    .quotient (quotient)
  );

  assign in_fire  = in_chan.valid && in_chan.ready;
  assign out_slot = !out_valid_r || out_chan.ready;

  // Sign-extend the word and take its offset from tare
  assign raw_ext   = DIFF_W'(signed'(word));
  assign tare_ext  = DIFF_W'(tare_r);
  assign diff      = raw_ext - tare_ext;
  assign diff_mag  = diff[DIFF_W-1] ? DATA_BITS'(-diff) : DATA_BITS'(diff);
  assign scale_mag = scale_r[SCALE_W-1] ? SCALE_W'(-scale_r) : SCALE_W'(scale_r);
  assign raw_out   = RAW_W'(raw_ext);

  // Hand the finishing tick to the arithmetic unit when it needs math
  assign defer = ser.last &&
                 ((ser.op == OP_MEASURE) || ((ser.op == OP_CAL) && (diff != '0)));
  assign req.start = in_fire && defer;
  assign req.op    = (ser.op == OP_CAL) ? AOP_DIV : AOP_MUL;

  // Floor-shift and saturate the product
  assign mul_over = |product[PROD_W-1:SAT_LSB];
  assign mul_q    = product[SAT_LSB-1:SCALE_FRACTION_BITS];
  assign mul_rem  = |product[SCALE_FRACTION_BITS-1:0];

  always_comb begin
    if (!neg_r) begin
      meas_val = mul_over ? VALUE_MAX : {1'b0, mul_q};
    end else begin
      meas_val = mul_over ? VALUE_MIN : (~{1'b0, mul_q} + VALUE_W'(!mul_rem));
    end
  end

  // Sign and saturate the quotient
  assign q_x      = QX_W'(quotient);
  assign cal_over = q_x > QX_W'(SCALE_MAX);

  always_comb begin
    if (!neg_r) begin
      cal_scale = cal_over ? SCALE_MAX : q_x[SCALE_W-1:0];
    end else begin
      cal_scale = cal_over ? SCALE_MIN : SCALE_W'(-q_x[SCALE_W-1:0]);
    end
  end

  // Controller next state
  always_comb begin
    ctl_nxt = ctl_r;
    case (ctl_r)
      CS_READY: begin
        if (in_fire && defer) begin
          ctl_nxt = CS_CALC;
        end
      end
      CS_CALC: begin
        if (!arith_busy && out_slot) begin
          ctl_nxt = CS_READY;
        end
      end
      default: begin
        ctl_nxt = CS_READY;
      end
    endcase
  end

  // Controller outputs
  always_comb begin
    in_chan.ready = (ctl_r == CS_READY) && out_slot;
    load_now      = in_fire && !defer;
    load_calc     = (ctl_r == CS_CALC) && !arith_busy && out_slot;
  end

  // Update calibration state and the output register
  always_comb begin
    tare_nxt       = tare_r;
    scale_nxt      = scale_r;
    conv_nxt       = conv_r;
    neg_nxt        = neg_r;
    dop_nxt        = dop_r;
    raw_hold_nxt   = raw_hold_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_sck_nxt    = out_sck_r;
    out_done_nxt   = out_done_r;
    out_status_nxt = out_status_r;
    out_raw_nxt    = out_raw_r;
    out_value_nxt  = out_value_r;
    out_conv_nxt   = out_conv_r;

    if (in_fire && ser.last) begin
      conv_nxt = conv_r + 1'b1;
      if (ser.op == OP_TARE) begin
        tare_nxt = signed'(word);
      end
    end

    if (req.start) begin
      neg_nxt      = (ser.op == OP_CAL) ? diff[DIFF_W-1] : (diff[DIFF_W-1] ^ scale_r[SCALE_W-1]);
      dop_nxt      = req.op;
      raw_hold_nxt = raw_out;
    end

    if (load_now) begin
      out_valid_nxt  = 1'b1;
      out_sck_nxt    = ser.sck;
      out_done_nxt   = ser.last;
      out_status_nxt = ser.last && (ser.op == OP_CAL);
      out_raw_nxt    = ser.last ? raw_out : '0;
      out_value_nxt  = '0;
      out_conv_nxt   = conv_nxt;
    end else if (load_calc) begin
      out_valid_nxt  = 1'b1;
      out_sck_nxt    = 1'b0;
      out_done_nxt   = 1'b1;
      out_status_nxt = 1'b0;
      out_raw_nxt    = raw_hold_r;
      out_value_nxt  = (dop_r == AOP_MUL) ? meas_val : '0;
      out_conv_nxt   = conv_r;
      if (dop_r == AOP_DIV) begin
        scale_nxt = signed'(cal_scale);
      end
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.sck         = out_sck_r;
  assign out_chan.done_res    = out_done_r;
  assign out_chan.status      = out_status_r;
  assign out_chan.raw         = out_raw_r;
  assign out_chan.value       = out_value_r;
  assign out_chan.conversions = out_conv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r       <= CS_READY;
      tare_r      <= '0;
      scale_r     <= signed'(SCALE_ONE);
      conv_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      ctl_r       <= ctl_nxt;
      tare_r      <= tare_nxt;
      scale_r     <= scale_nxt;
      conv_r      <= conv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r        <= neg_nxt;
    dop_r        <= dop_nxt;
    raw_hold_r   <= raw_hold_nxt;
    out_sck_r    <= out_sck_nxt;
    out_done_r   <= out_done_nxt;
    out_status_r <= out_status_nxt;
    out_raw_r    <= out_raw_nxt;
    out_value_r  <= out_value_nxt;
    out_conv_r   <= out_conv_nxt;
  end

  a_unit_idle_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl_r == CS_READY) |-> !arith_busy)
    else $error("arithmetic unit busy while controller takes ticks");

  a_start_enters_calc: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |=> (ctl_r == CS_CALC) && arith_busy)
    else $error("deferred tick did not start the arithmetic unit");

  a_plain_tick_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_done_r |-> (out_raw_r == '0) && (out_value_r == '0) && !out_status_r)
    else $error("result fields set on a tick without a finished conversion");

endmodule
